// ----- rtl/dpd_pkg.sv -----
package dpd_pkg;

  localparam int unsigned MaxBoards      = 8;
  localparam int unsigned ModuleWords    = 8;
  localparam int unsigned RecordOverhead = 3;
  localparam int unsigned MinDepth       = 8;
  localparam int unsigned MaxDepth       = 64;
  localparam int unsigned BlockBits      = 64;
  // input requests wait this long so derived config is settled when they are parsed
  localparam int unsigned PipeStages     = 3;

  typedef enum logic [1:0] {
    KIND_GRAD   = 2'd0,
    KIND_PULSE  = 2'd1,
    KIND_SAMPLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_BOARD_MASK      = 2'd0,
    CFG_CHANNEL_DEPTH   = 2'd1,
    CFG_BLOCKED_MODULES = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]           depth;
    logic [3:0]           boards;
    logic [9:0]           pulse_size;
    logic [9:0]           total;
    logic [9:0]           last_mod;
    logic [BlockBits-1:0] blocked;
  } cfg_t;

endpackage

// ----- rtl/dpd_cfg.sv -----
module dpd_cfg
  import dpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  output cfg_t        cfg_o
);

  logic [7:0]           mask_q;
  logic [6:0]           depth_q;
  logic [BlockBits-1:0] blocked_q;

  cfg_t d1_d, d1_q, d2_d, d2_q;

  logic [3:0]  ones;
  logic [6:0]  depth_eff;
  logic [10:0] pulse_prod;
  logic [10:0] total_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= '0;
      depth_q   <= 7'(MaxDepth);
      blocked_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOARD_MASK:      mask_q    <= cfg_data_i[7:0];
        CFG_CHANNEL_DEPTH:   depth_q   <= cfg_data_i[6:0];
        CFG_BLOCKED_MODULES: blocked_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: clamped depth, board count, pulse and sample totals
  always_comb begin
    ones = '0;
    for (int i = 0; i < 8; i++) begin
      ones = ones + 4'(mask_q[i]);
    end
    if (ones > 4'(MaxBoards)) ones = 4'(MaxBoards);

    depth_eff = depth_q;
    if (depth_q < 7'(MinDepth)) depth_eff = 7'(MinDepth);
    if (depth_q > 7'(MaxDepth)) depth_eff = 7'(MaxDepth);

    pulse_prod = 11'(ones) * (11'(depth_eff) + 11'(RecordOverhead));
    total_prod = 11'(ones) * 11'(depth_eff);

    d1_d            = '0;
    d1_d.depth      = depth_eff;
    d1_d.boards     = ones;
    d1_d.pulse_size = pulse_prod[9:0];
    d1_d.total      = total_prod[9:0];
    d1_d.blocked    = blocked_q;
  end

  // stage 2: highest module that is present and not blocked
  always_comb begin
    d2_d          = d1_q;
    d2_d.last_mod = '0;
    if (32'(d1_q.total) > BlockBits * ModuleWords) begin
      d2_d.last_mod = 10'((32'(d1_q.total) - 32'd1) / ModuleWords);
    end else begin
      for (int i = 0; i < BlockBits; i++) begin
        if ((i * ModuleWords) < int'(d1_q.total) && !d1_q.blocked[i]) begin
          d2_d.last_mod = 10'(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '{depth: 7'(MaxDepth), default: '0};
      d2_q <= '{depth: 7'(MaxDepth), default: '0};
    end else begin
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
  end

  assign cfg_o = d2_q;

endmodule

// ----- rtl/dpd_core.sv -----
module dpd_core
  import dpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_cmd_i,
  input  logic [31:0] in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output kind_e       out_kind_o,
  output logic [31:0] out_value_o,
  output logic [8:0]  out_chan_o,
  output logic        out_eop_o,
  output logic [31:0] out_grad_o
);

  logic [29:0] pkt_left_q, pkt_left_d;
  logic [9:0]  pulse_left_q, pulse_left_d;
  logic [2:0]  bp_q, bp_d;
  logic [6:0]  wir_q, wir_d;
  logic [8:0]  kept_q, kept_d;
  logic [31:0] grad_cnt_q, grad_cnt_d;
  logic [31:0] prev_grad_q, prev_grad_d;
  logic        prev_valid_q, prev_valid_d;

  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [31:0] value_q;
  logic [8:0]  chan_q, chan_d;
  logic        eop_q, eop_d;
  logic [31:0] grad_q;

  logic        fire, emit;
  logic [29:0] words;
  logic        start;
  logic [9:0]  pulse_eff;
  logic [2:0]  bp_eff;
  logic [6:0]  r;
  logic [8:0]  kept_eff;
  logic [9:0]  g, m, g_rem;
  logic        blk, samp_eop;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  always_comb begin
    words = in_word_i[31:2];
    if (words == '0) words = 30'd1;
    start     = (pulse_left_q == '0);
    pulse_eff = start ? cfg_i.pulse_size : pulse_left_q;
    bp_eff    = start ? 3'd0 : bp_q;
    r         = start ? 7'd0 : wir_q;
    kept_eff  = start ? 9'd0 : kept_q;
  end

  // sample position across boards, module, end-of-pulse look-ahead
  always_comb begin
    g        = 10'(bp_eff) * 10'(cfg_i.depth) + 10'(r - 7'd2);
    m        = 10'(g / 10'(ModuleWords));
    g_rem    = 10'(g % 10'(ModuleWords));
    blk      = (m < 10'(BlockBits)) && cfg_i.blocked[m[5:0]];
    samp_eop = (g >= cfg_i.total) ||
               (((g_rem == 10'(ModuleWords - 1)) || (g == cfg_i.total - 10'd1)) &&
                (m == cfg_i.last_mod));
  end

  always_comb begin
    pkt_left_d   = pkt_left_q;
    pulse_left_d = pulse_left_q;
    bp_d         = bp_q;
    wir_d        = wir_q;
    kept_d       = kept_q;
    grad_cnt_d   = grad_cnt_q;
    prev_grad_d  = prev_grad_q;
    prev_valid_d = prev_valid_q;
    emit         = 1'b0;
    kind_d       = KIND_GRAD;
    chan_d       = '0;
    eop_d        = 1'b0;

    if (in_cmd_i) begin
      grad_cnt_d   = '0;
      prev_valid_d = 1'b0;
    end else if (pkt_left_q == '0) begin
      pkt_left_d   = words - 30'd1;
      pulse_left_d = '0;
    end else if (start && (cfg_i.pulse_size == '0 ||
                           pkt_left_q < 30'(cfg_i.pulse_size))) begin
      pkt_left_d = pkt_left_q - 30'd1;
    end else begin
      pkt_left_d = pkt_left_q - 30'd1;
      bp_d       = bp_eff;
      wir_d      = r;
      kept_d     = kept_eff;
      if (8'(r) >= 8'(cfg_i.depth) + 8'd2) begin
        // checksum closes the record
        wir_d = '0;
        bp_d  = bp_eff + 3'd1;
      end else begin
        if (r == 7'd0) begin
          if (bp_eff == '0) begin
            if (!prev_valid_q || in_word_i != prev_grad_q) begin
              grad_cnt_d   = grad_cnt_q + 32'd1;
              prev_grad_d  = in_word_i;
              prev_valid_d = 1'b1;
            end
            emit   = 1'b1;
            kind_d = KIND_GRAD;
          end
        end else if (r == 7'd1) begin
          if (bp_eff == '0) begin
            emit   = 1'b1;
            kind_d = KIND_PULSE;
          end
        end else if (!blk) begin
          emit   = 1'b1;
          kind_d = KIND_SAMPLE;
          chan_d = kept_eff;
          eop_d  = samp_eop;
          kept_d = kept_eff + 9'd1;
        end
        wir_d = r + 7'd1;
      end
      pulse_left_d = pulse_eff - 10'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_left_q   <= '0;
      pulse_left_q <= '0;
      bp_q         <= '0;
      wir_q        <= '0;
      kept_q       <= '0;
      grad_cnt_q   <= '0;
      prev_grad_q  <= '0;
      prev_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        pkt_left_q   <= pkt_left_d;
        pulse_left_q <= pulse_left_d;
        bp_q         <= bp_d;
        wir_q        <= wir_d;
        kept_q       <= kept_d;
        grad_cnt_q   <= grad_cnt_d;
        prev_grad_q  <= prev_grad_d;
        prev_valid_q <= prev_valid_d;
      end
      if (in_ready_o) out_valid_q <= fire && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      kind_q  <= kind_d;
      value_q <= in_word_i;
      chan_q  <= chan_d;
      eop_q   <= eop_d;
      grad_q  <= grad_cnt_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_value_o = value_q;
  assign out_chan_o  = chan_q;
  assign out_eop_o   = eop_q;
  assign out_grad_o  = grad_q;

  a_pulse_in_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_left_q != '0 |-> pkt_left_q >= 30'(pulse_left_q))
    else $error("pulse overruns packet");

  a_header_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KIND_SAMPLE |-> chan_q == '0 && !eop_q)
    else $error("header result carries sample fields");

  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_cmd_i |=> grad_cnt_q == '0 && !prev_valid_q && !out_valid_q)
    else $error("start request did not clear graduation tracking");

endmodule

// ----- rtl/detector_pulse_deframer_top.sv -----
// Channel  | Dir | Signals               | Payload
// s_axis   | in  | tvalid/tready/tdata/tuser | tdata: stream_word; tuser: command
// m_axis   | out | tvalid/tready/tdata/tuser/tlast | tdata: value, channel_index,
//          |     |                       |   graduation_total; tuser: kind; tlast: end_of_pulse
// cfg      | in  | cfg_we_i/idx/data      | 0 board_mask, 1 samples_per_record, 2 blocked_modules
//
// One request per cycle sustained while m_axis_tready stays high.
// Three input stages cover the derived-config pipeline (d1, d2 registers), then a single
// parse stage updates the framing counters and loads the result register.
// Reset clears framing, graduation tracking, mask and blocks, sets depth 64; no clearing pass.
// A stalled m_axis backs up the stages; s_axis_tready falls only when all are full.
module detector_pulse_deframer_top
  import dpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] stream_word
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [31:0] value, [40:32] channel_index,
                                      // [72:41] graduation_total, [79:73] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // end_of_pulse
);

  cfg_t cfg;

  logic [PipeStages-1:0] vld_q;
  logic [PipeStages-1:0] cmd_q;
  logic [31:0]           word_q [PipeStages];
  logic [PipeStages:0]   adv;

  logic        core_rdy;
  kind_e       kind;
  logic [31:0] value;
  logic [8:0]  chan;
  logic [31:0] grad;

  dpd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_comb begin
    adv[PipeStages] = core_rdy;
    for (int k = PipeStages - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < PipeStages; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cmd_q[0]  <= s_axis_tuser;
      word_q[0] <= s_axis_tdata;
    end
    for (int k = 1; k < PipeStages; k++) begin
      if (adv[k]) begin
        cmd_q[k]  <= cmd_q[k-1];
        word_q[k] <= word_q[k-1];
      end
    end
  end

  dpd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (vld_q[PipeStages-1]),
    .in_ready_o  (core_rdy),
    .in_cmd_i    (cmd_q[PipeStages-1]),
    .in_word_i   (word_q[PipeStages-1]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_kind_o  (kind),
    .out_value_o (value),
    .out_chan_o  (chan),
    .out_eop_o   (m_axis_tlast),
    .out_grad_o  (grad)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {7'd0, grad, chan, value};

endmodule

// ----- dv/tb_detector_pulse_deframer_top.sv -----
module tb_detector_pulse_deframer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dpd_pkg::*;

  localparam int unsigned WordTarget    = 1550;
  localparam int unsigned LastPhaseSize = 560;
  localparam int unsigned PhaseWords    = 60;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic        cmd;
    logic [31:0] word;
  } stream_req_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] value;
    logic [8:0]  chan;
    logic        eop;
    logic [31:0] grad_total;
  } deframed_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  detector_pulse_deframer_top DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // request queues and bookkeeping
  stream_req_t pending_words[$];
  deframed_t   expected_results[$];
  logic [31:0] packet_buf[$];
  logic [31:0] carry_buf[$];
  int unsigned words_queued = 0;
  int unsigned words_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned src_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned stuck_cycles = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;
  stream_req_t next_req;
  deframed_t   want;

  // configuration as seen by the block
  logic [7:0]  cfg_mask = 8'd0;
  logic [6:0]  cfg_depth = 7'd64;
  logic [63:0] cfg_blocked = 64'd0;

  // deframer state
  logic [29:0] frame_words_left = '0;
  logic [9:0]  pulse_words_todo = '0;
  logic [2:0]  board_slot = '0;
  logic [6:0]  record_pos = '0;
  logic [8:0]  kept_samples = '0;
  logic [31:0] grad_changes = '0;
  logic [31:0] last_grad = '0;
  logic        last_grad_seen = 1'b0;

  // stimulus view of the current layout
  int unsigned gen_nb = 0;
  int unsigned gen_dep = 64;
  int unsigned gen_psize = 0;
  logic [31:0] gen_grad = '0;

  function automatic bit module_blocked(int unsigned m);
    return (m < BlockBits) ? cfg_blocked[6'(m)] : 1'b0;
  endfunction

  // no kept sample follows position g in the pulse
  function automatic bit last_kept(int unsigned g, int unsigned total);
    int unsigned m;
    int unsigned stop;
    m = g / ModuleWords;
    stop = (m + 1) * ModuleWords - 1;
    if (stop > total - 1) stop = total - 1;
    if (g < stop) return 1'b0;
    for (m = m + 1; m * ModuleWords < total; m++)
      if (!module_blocked(m)) return 1'b0;
    return 1'b1;
  endfunction

  task automatic deframe_word(logic cmd, logic [31:0] w);
    int unsigned dep;
    int unsigned nb;
    int unsigned psize;
    int unsigned r;
    int unsigned g;
    int unsigned total;
    int unsigned words;
    deframed_t   res;
    bit          emit;
    dep = 32'(cfg_depth);
    if (dep < MinDepth) dep = MinDepth;
    if (dep > MaxDepth) dep = MaxDepth;
    nb = $countones(cfg_mask);
    psize = nb * (dep + RecordOverhead);
    emit = 1'b0;
    res.kind = KIND_GRAD;
    res.value = w;
    res.chan = '0;
    res.eop = 1'b0;
    res.grad_total = '0;
    if (cmd) begin
      grad_changes = '0;
      last_grad_seen = 1'b0;
      return;
    end
    if (frame_words_left == 0) begin
      words = w >> 2;
      if (words < 1) words = 1;
      frame_words_left = 30'(words - 1);
      pulse_words_todo = '0;
      return;
    end
    if (pulse_words_todo == 0) begin
      if (psize == 0 || frame_words_left < psize) begin
        frame_words_left = 30'(frame_words_left - 1);
        return;
      end
      pulse_words_todo = 10'(psize);
      board_slot = '0;
      record_pos = '0;
      kept_samples = '0;
    end
    frame_words_left = 30'(frame_words_left - 1);
    r = 32'(record_pos);
    if (r >= dep + 2) begin
      // checksum closes the record
      record_pos = '0;
      board_slot = 3'(board_slot + 1);
    end else begin
      if (r == 0) begin
        if (board_slot == 0) begin
          if (!last_grad_seen || w != last_grad) begin
            grad_changes = grad_changes + 1;
            last_grad = w;
            last_grad_seen = 1'b1;
          end
          res.kind = KIND_GRAD;
          emit = 1'b1;
        end
      end else if (r == 1) begin
        if (board_slot == 0) begin
          res.kind = KIND_PULSE;
          emit = 1'b1;
        end
      end else begin
        g = board_slot * dep + (r - 2);
        total = nb * dep;
        if (!module_blocked(g / ModuleWords)) begin
          res.kind = KIND_SAMPLE;
          res.chan = kept_samples;
          res.eop = (g >= total) || last_kept(g, total);
          kept_samples = 9'(kept_samples + 1);
          emit = 1'b1;
        end
      end
      record_pos = 7'(r + 1);
    end
    pulse_words_todo = 10'(pulse_words_todo - 1);
    if (emit) begin
      res.grad_total = grad_changes;
      expected_results.insert(expected_results.size(), res);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOARD_MASK:      cfg_mask = cfg_data_i[7:0];
        CFG_CHANNEL_DEPTH:   cfg_depth = cfg_data_i[6:0];
        CFG_BLOCKED_MODULES: cfg_blocked = cfg_data_i;
        default: ;
      endcase
    end
  end

  // stream driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_word(s_axis_tuser, s_axis_tdata);
        words_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          next_req = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= next_req.word;
          s_axis_tuser <= next_req.cmd;
          if (src_idle_en) src_gap = pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(string field, logic [31:0] exp_val, logic [31:0] act_val);
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $realtime, field, exp_val,
             act_val);
    mismatches++;
  endtask

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual kind %0d value 0x%0h",
                   $realtime, m_axis_tuser, m_axis_tdata[31:0]);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser !== want.kind)
            report_field("kind", 32'(want.kind), 32'(m_axis_tuser));
          if (m_axis_tdata[31:0] !== want.value)
            report_field("value", want.value, m_axis_tdata[31:0]);
          if (m_axis_tdata[40:32] !== want.chan)
            report_field("channel_index", 32'(want.chan), 32'(m_axis_tdata[40:32]));
          if (m_axis_tdata[72:41] !== want.grad_total)
            report_field("graduation_total", want.grad_total, m_axis_tdata[72:41]);
          if (m_axis_tdata[79:73] !== 7'd0)
            report_field("tdata pad", 32'd0, 32'(m_axis_tdata[79:73]));
          if (m_axis_tlast !== want.eop)
            report_field("end_of_pulse", 32'(want.eop), 32'(m_axis_tlast));
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (sink_idle_en) sink_stall = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_item(logic cmd, logic [31:0] word);
    stream_req_t req;
    req.cmd = cmd;
    req.word = word;
    pending_words.insert(pending_words.size(), req);
    words_queued++;
  endtask

  // occasional start command between stream words
  task automatic push_stream(logic [31:0] word);
    if ($urandom_range(0, 49) == 0) push_item(1'b1, $urandom);
    push_item(1'b0, word);
  endtask

  task automatic wait_drained();
    while (words_accepted != words_queued || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] mask, logic [6:0] depth, logic [63:0] blocked);
    write_reg(CFG_BOARD_MASK, {56'd0, mask});
    write_reg(CFG_CHANNEL_DEPTH, {57'd0, depth});
    write_reg(CFG_BLOCKED_MODULES, blocked);
    gen_dep = (depth < MinDepth) ? MinDepth : (depth > MaxDepth) ? MaxDepth : depth;
    gen_nb = $countones(mask);
    gen_psize = gen_nb * (gen_dep + RecordOverhead);
  endtask

  task automatic add_pulse();
    int unsigned b;
    if ($urandom_range(0, 2) != 0) gen_grad = $urandom_range(0, 1) ? gen_grad + 1 : $urandom;
    for (b = 0; b < gen_nb; b++) begin
      packet_buf.insert(packet_buf.size(), (b == 0) ? gen_grad : $urandom);
      packet_buf.insert(packet_buf.size(), $urandom);
      repeat (gen_dep) packet_buf.insert(packet_buf.size(), $urandom);
      packet_buf.insert(packet_buf.size(), $urandom);
    end
  endtask

  task automatic build_packet();
    int unsigned np;
    int unsigned extra;
    int unsigned words;
    int unsigned cap;
    packet_buf.delete();
    if ($urandom_range(0, 99) < 75) begin
      np = (gen_psize == 0) ? 0 : (gen_psize > PhaseWords) ? 1 : $urandom_range(1, 3);
      extra = 0;
      if ($urandom_range(0, 3) == 0) begin
        // trailing words short of a whole pulse
        cap = (gen_psize > 1) ? gen_psize - 1 : 4;
        if (cap > 30) cap = 30;
        extra = $urandom_range(1, cap);
      end
      words = 1 + np * gen_psize + extra;
      packet_buf.insert(packet_buf.size(),
                        words * 4 + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0));
      repeat (np) add_pulse();
      repeat (extra) packet_buf.insert(packet_buf.size(), $urandom);
    end else begin
      // odd or short lengths, random body
      words = $urandom_range(0, 40);
      packet_buf.insert(packet_buf.size(), words * 4 + $urandom_range(0, 3));
      if (words > 1) repeat (words - 1) packet_buf.insert(packet_buf.size(), $urandom);
    end
  endtask

  task automatic run_phase(logic [7:0] mask, logic [6:0] depth, logic [63:0] blocked,
                           bit may_split);
    int unsigned start;
    int unsigned cut;
    int unsigned i;
    bit          split;
    wait_drained();
    set_config(mask, depth, blocked);
    src_idle_en = $urandom_range(0, 3) != 0;
    sink_idle_en = $urandom_range(0, 3) != 0;
    // rest of a packet cut off in the last phase, now seen under the new layout
    while (carry_buf.size() > 0) push_stream(carry_buf.pop_front());
    start = words_queued;
    split = 1'b0;
    while (!split && words_queued - start < PhaseWords) begin
      build_packet();
      cut = packet_buf.size();
      if (may_split && cut > 1 && words_queued - start + cut >= PhaseWords &&
          $urandom_range(0, 2) == 0) begin
        cut = $urandom_range(1, cut - 1);
        split = 1'b1;
      end
      for (i = 0; i < packet_buf.size(); i++) begin
        if (i < cut) push_stream(packet_buf[i]);
        else carry_buf.insert(carry_buf.size(), packet_buf[i]);
      end
    end
  endtask

  initial begin
    logic [7:0]  mask;
    logic [6:0]  depth;
    logic [63:0] blocked;
    int unsigned sel;
    int unsigned k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no boards enabled: short lengths, skipped body, start command
    push_item(1'b0, 32'd0);
    push_item(1'b0, 32'd3);
    push_item(1'b0, 32'd13);
    push_item(1'b0, 32'd0);
    push_item(1'b0, 32'hFFFF_FFFF);
    push_item(1'b1, 32'hFFFF_FFFF);
    wait_drained();

    // one board, minimum depth, one whole pulse
    set_config(8'h01, 7'd8, 64'd0);
    push_item(1'b0, 32'd48);
    push_item(1'b0, 32'hFFFF_FFFF);
    push_item(1'b0, 32'd0);
    push_item(1'b0, 32'd0);
    push_item(1'b0, 32'hFFFF_FFFF);
    for (k = 1; k < 7; k++) push_item(1'b0, k);
    push_item(1'b1, 32'd0);
    push_item(1'b0, 32'h0123_4567);

    run_phase(8'hFF, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    run_phase(8'h80, 7'd127, 64'd0, 1'b1);
    while (words_queued < WordTarget - LastPhaseSize) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) mask = 8'h00;
      else if (sel == 1) mask = 8'hFF;
      else if (sel < 6) mask = 8'h01 << $urandom_range(0, 7);
      else mask = 8'($urandom);
      sel = $urandom_range(0, 9);
      if (sel == 0) depth = 7'($urandom_range(0, 7));
      else if (sel == 1) depth = 7'($urandom_range(65, 127));
      else if (sel == 2) depth = 7'd64;
      else if (sel == 3) depth = 7'($urandom_range(9, 63));
      else depth = 7'($urandom_range(1, 2) * 8);
      if ($countones(mask) > 2 && depth > 16) depth = 7'd8;
      sel = $urandom_range(0, 5);
      if (sel == 0) blocked = 64'd0;
      else if (sel == 1) blocked = '1;
      else if (sel == 2) blocked = {$urandom, $urandom};
      else if (sel == 3) blocked = 64'd1 << $urandom_range(0, 63);
      else blocked = {$urandom, $urandom} & {$urandom, $urandom};
      run_phase(mask, depth, blocked, 1'b1);
    end
    run_phase(8'hFF, 7'd64, {$urandom, $urandom}, 1'b0);
    wait_drained();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dpd_pkg.sv
rtl/dpd_cfg.sv
rtl/dpd_core.sv
rtl/detector_pulse_deframer_top.sv
dv/tb_detector_pulse_deframer_top.sv
